[rtl/phcd_pkg.sv]
// ----------------------------------------------------------------------------
// phcd_pkg
// Shared types, codes and the header CRC helpers for the packet header
// CRC deframer.
// ----------------------------------------------------------------------------
package phcd_pkg;

   localparam int BYTE_W     = 8;
   localparam int HDR_W      = 32;
   localparam int BODY_W     = 28;
   localparam int SHIFT_W    = 24;
   localparam int LEN_W      = 13;
   localparam int KIND_W     = 3;
   localparam int CRC_W      = 4;
   localparam int NIBBLES    = BODY_W / 4;

   localparam logic [CRC_W-1:0] CRC_POLY = 4'h7;

   // Event codes
   localparam logic [KIND_W-1:0] EV_BEACON  = 3'd0;
   localparam logic [KIND_W-1:0] EV_PING    = 3'd1;
   localparam logic [KIND_W-1:0] EV_ERROR   = 3'd2;
   localparam logic [KIND_W-1:0] EV_PAYLOAD = 3'd3;
   localparam logic [KIND_W-1:0] EV_CRC_BAD = 3'd4;

   // Header type codes (header bits 3..0)
   localparam logic [3:0] TYPE_BEACON   = 4'd5;
   localparam logic [3:0] TYPE_PING     = 4'd6;
   localparam logic [3:0] TYPE_ERROR    = 4'd15;
   localparam logic [3:0] TYPE_RESPONSE = 4'd10;
   localparam logic [3:0] TYPE_ASYNC    = 4'd9;

   // Payload kind codes
   localparam logic PKIND_RESPONSE = 1'b0;
   localparam logic PKIND_ASYNC    = 1'b1;

   typedef struct packed {
      logic                has_result;
      logic [KIND_W-1:0]   kind;
      logic                start_payload;
      logic                payload_kind;
      logic [LEN_W-1:0]    length;
   } hdr_decode_type;

   // Bit-serial form of the header CRC: nibbles low first, each MSB first.
   function automatic logic [CRC_W-1:0] crc4_serial(input logic [BODY_W-1:0] body);
      logic [CRC_W-1:0] crc;
      logic             fb;
      crc = '0;
      for (int i = 0; i < NIBBLES; i++) begin
         for (int j = 3; j >= 0; j--) begin
            fb  = crc[CRC_W-1] ^ body[4*i+j];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
               crc = crc ^ CRC_POLY;
            end
         end
      end
      return crc;
   endfunction

   // The CRC is linear: build one parity mask per CRC bit at elaboration.
   function automatic logic [CRC_W-1:0][BODY_W-1:0] crc4_masks();
      logic [CRC_W-1:0][BODY_W-1:0] m;
      logic [CRC_W-1:0]             c;
      m = '0;
      for (int b = 0; b < BODY_W; b++) begin
         c = crc4_serial(BODY_W'(1) << b);
         for (int k = 0; k < CRC_W; k++) begin
            m[k][b] = c[k];
         end
      end
      return m;
   endfunction

   localparam logic [CRC_W-1:0][BODY_W-1:0] CRC_MASKS = crc4_masks();

endpackage

[rtl/phcd_hdr_decode.sv]
// ----------------------------------------------------------------------------
// phcd_hdr_decode
// Checks the 4-bit CRC of a complete header and sorts it by type.
// ----------------------------------------------------------------------------
module phcd_hdr_decode
   import phcd_pkg::*;
(
   input  logic [HDR_W-1:0] header,
   output hdr_decode_type   decode
);

   logic [CRC_W-1:0] crc_calc;
   logic [3:0]       hdr_type;
   logic [LEN_W-1:0] hdr_len;

   always_comb begin
      for (int k = 0; k < CRC_W; k++) begin
         crc_calc[k] = ^(header[BODY_W-1:0] & CRC_MASKS[k]);
      end
   end

   assign hdr_type = header[3:0];
   assign hdr_len  = header[LEN_W+3:4];

   always_comb begin
      decode = '0;
      decode.length = hdr_len;
      if (crc_calc != header[HDR_W-1:BODY_W]) begin
         decode.has_result = 1'b1;
         decode.kind       = EV_CRC_BAD;
      end else begin
         case (hdr_type)
            TYPE_BEACON: begin
               decode.has_result = 1'b1;
               decode.kind       = EV_BEACON;
            end
            TYPE_PING: begin
               decode.has_result = 1'b1;
               decode.kind       = EV_PING;
            end
            TYPE_ERROR: begin
               decode.has_result = 1'b1;
               decode.kind       = EV_ERROR;
            end
            TYPE_RESPONSE, TYPE_ASYNC: begin
               // zero length: nothing follows, stay on headers
               decode.start_payload = (hdr_len != '0);
               decode.payload_kind  = (hdr_type == TYPE_ASYNC) ? PKIND_ASYNC
                                                               : PKIND_RESPONSE;
            end
            default: begin
               decode.has_result = 1'b0;
            end
         endcase
      end
   end

endmodule

[rtl/packet_header_crc_deframer.sv]
// ----------------------------------------------------------------------------
// packet_header_crc_deframer
// Gathers 4-byte headers from a byte stream, checks their CRC, reports
// beacon, ping, error and bad-CRC events, and streams out payload bytes.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while req_stall is low; each is handled in the
// cycle it is accepted and any event it causes appears on the rsp_ port on
// the next cycle from a single output register. req_stall is high only while
// that register holds an item and rsp_stall is high, so the sustained rate is
// one byte per cycle whenever the result side keeps up. Header bytes one to
// three produce no event; the fourth byte yields at most one event, and each
// payload byte yields one payload event with payload_last on the final byte.
module packet_header_crc_deframer
   import phcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_event_kind,
   output logic [BODY_W-1:0]   rsp_header_body,
   output logic [BYTE_W-1:0]   rsp_error_code,
   output logic [BYTE_W-1:0]   rsp_payload_byte,
   output logic                rsp_payload_kind,
   output logic                rsp_payload_last
);

   // Framing state
   logic                in_payload_ff,        in_payload_in;
   logic [1:0]          hdr_count_ff,         hdr_count_in;
   logic [SHIFT_W-1:0]  hdr_shift_ff,         hdr_shift_in;
   logic [LEN_W-1:0]    remaining_ff,         remaining_in;
   logic                cur_kind_ff,          cur_kind_in;

   // Output register
   logic                rsp_valid_ff,         rsp_valid_in;
   logic [KIND_W-1:0]   event_kind_ff,        event_kind_in;
   logic [BODY_W-1:0]   header_body_ff,       header_body_in;
   logic [BYTE_W-1:0]   error_code_ff,        error_code_in;
   logic [BYTE_W-1:0]   payload_byte_ff,      payload_byte_in;
   logic                payload_kind_ff,      payload_kind_in;
   logic                payload_last_ff,      payload_last_in;

   logic                accept;
   logic                rsp_take;
   logic [HDR_W-1:0]    header;
   logic [LEN_W-1:0]    remaining_dec;
   hdr_decode_type      decode;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;

   assign header        = {req_rx_byte, hdr_shift_ff};
   assign remaining_dec = remaining_ff - LEN_W'(1);

   phcd_hdr_decode u_hdr_decode (
      .header (header),
      .decode (decode)
   );

   always_comb begin
      in_payload_in   = in_payload_ff;
      hdr_count_in    = hdr_count_ff;
      hdr_shift_in    = hdr_shift_ff;
      remaining_in    = remaining_ff;
      cur_kind_in     = cur_kind_ff;

      rsp_valid_in    = rsp_take ? 1'b0 : rsp_valid_ff;
      event_kind_in   = event_kind_ff;
      header_body_in  = header_body_ff;
      error_code_in   = error_code_ff;
      payload_byte_in = payload_byte_ff;
      payload_kind_in = payload_kind_ff;
      payload_last_in = payload_last_ff;

      if (accept) begin
         if (in_payload_ff) begin
            remaining_in    = remaining_dec;
            rsp_valid_in    = 1'b1;
            event_kind_in   = EV_PAYLOAD;
            header_body_in  = '0;
            error_code_in   = '0;
            payload_byte_in = req_rx_byte;
            payload_kind_in = cur_kind_ff;
            payload_last_in = (remaining_dec == '0);
            if (remaining_dec == '0) begin
               in_payload_in = 1'b0;
            end
         end else if (hdr_count_ff != 2'd3) begin
            // shift this byte into its lane of the header
            case (hdr_count_ff)
               2'd0:    hdr_shift_in[7:0]   = req_rx_byte;
               2'd1:    hdr_shift_in[15:8]  = req_rx_byte;
               2'd2:    hdr_shift_in[23:16] = req_rx_byte;
               default: hdr_shift_in        = hdr_shift_ff;
            endcase
            hdr_count_in = hdr_count_ff + 2'd1;
         end else begin
            hdr_count_in = '0;
            hdr_shift_in = '0;
            if (decode.has_result) begin
               rsp_valid_in    = 1'b1;
               event_kind_in   = decode.kind;
               header_body_in  = (decode.kind == EV_BEACON || decode.kind == EV_PING)
                                 ? header[BODY_W-1:0] : '0;
               error_code_in   = (decode.kind == EV_ERROR) ? header[15:8] : '0;
               payload_byte_in = '0;
               payload_kind_in = 1'b0;
               payload_last_in = 1'b0;
            end
            if (decode.start_payload) begin
               in_payload_in = 1'b1;
               remaining_in  = decode.length;
               cur_kind_in   = decode.payload_kind;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         hdr_count_ff  <= '0;
         hdr_shift_ff  <= '0;
         remaining_ff  <= '0;
         cur_kind_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_payload_ff <= in_payload_in;
         hdr_count_ff  <= hdr_count_in;
         hdr_shift_ff  <= hdr_shift_in;
         remaining_ff  <= remaining_in;
         cur_kind_ff   <= cur_kind_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      event_kind_ff   <= event_kind_in;
      header_body_ff  <= header_body_in;
      error_code_ff   <= error_code_in;
      payload_byte_ff <= payload_byte_in;
      payload_kind_ff <= payload_kind_in;
      payload_last_ff <= payload_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = event_kind_ff;
   assign rsp_header_body  = header_body_ff;
   assign rsp_error_code   = error_code_ff;
   assign rsp_payload_byte = payload_byte_ff;
   assign rsp_payload_kind = payload_kind_ff;
   assign rsp_payload_last = payload_last_ff;

endmodule

[rtl/phcd_checker.sv]
// ----------------------------------------------------------------------------
// phcd_checker
// Port-level checks for the packet header CRC deframer.
// ----------------------------------------------------------------------------
module phcd_checker
   import phcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KIND_W-1:0]   rsp_event_kind,
   input  logic [BODY_W-1:0]   rsp_header_body,
   input  logic [BYTE_W-1:0]   rsp_error_code,
   input  logic [BYTE_W-1:0]   rsp_payload_byte,
   input  logic                rsp_payload_kind,
   input  logic                rsp_payload_last
);

   // A held item keeps its event kind, payload byte and payload_last.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_last))
      else $error("rsp item changed while stalled");

   // Backpressure comes only from a full, stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a held result");

   // Payload fields appear only on payload events.
   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != EV_PAYLOAD)
         |-> !rsp_payload_last && !rsp_payload_kind && (rsp_payload_byte == '0))
      else $error("payload fields set on a non-payload event");

   // A bad-CRC event carries nothing else.
   a_crc_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_CRC_BAD)
         |-> (rsp_header_body == '0) && (rsp_error_code == '0))
      else $error("bad-CRC event carries data");

   // Event codes stay in range.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == EV_BEACON) || (rsp_event_kind == EV_PING)
         || (rsp_event_kind == EV_ERROR) || (rsp_event_kind == EV_PAYLOAD)
         || (rsp_event_kind == EV_CRC_BAD))
      else $error("undefined event kind");

endmodule

bind packet_header_crc_deframer phcd_checker u_phcd_checker (.*);

[tb/phcd_deframe_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phcd_deframe_checker
// Watches both channels of the deframer, predicts the event stream from
// the accepted bytes and compares every accepted event field by field.
// ----------------------------------------------------------------------------

package deframe_crc_pkg;
   import phcd_pkg::*;

   // Bits go in nibble by nibble from the low end, each nibble MSB first.
   function automatic logic [CRC_W-1:0] header_crc4(input logic [BODY_W-1:0] body);
      logic [CRC_W-1:0] crc;
      logic             feedback;
      int               pos;
      crc = '0;
      for (int i = 0; i < BODY_W; i++) begin
         pos      = (i / 4) * 4 + 3 - (i % 4);
         feedback = crc[CRC_W-1] ^ body[pos];
         crc      = {crc[CRC_W-2:0], 1'b0} ^ (feedback ? CRC_POLY : '0);
      end
      return crc;
   endfunction

endpackage

module phcd_deframe_checker
   import phcd_pkg::*;
   import deframe_crc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,

   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KIND_W-1:0]   rsp_event_kind,
   input  logic [BODY_W-1:0]   rsp_header_body,
   input  logic [BYTE_W-1:0]   rsp_error_code,
   input  logic [BYTE_W-1:0]   rsp_payload_byte,
   input  logic                rsp_payload_kind,
   input  logic                rsp_payload_last,

   output int                  fail_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [KIND_W-1:0]   event_kind;
      logic [BODY_W-1:0]   header_body;
      logic [BYTE_W-1:0]   error_code;
      logic [BYTE_W-1:0]   payload_byte;
      logic                payload_kind;
      logic                payload_last;
   } deframe_event_t;

   deframe_event_t expected_events[$];

   logic                in_payload;
   logic [1:0]          hdr_count;
   logic [SHIFT_W-1:0]  hdr_shift;
   logic [LEN_W-1:0]    bytes_left;
   logic                cur_kind;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [BODY_W-1:0] got,
                                  input logic [BODY_W-1:0] want);
      $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic compare_field(input string what, input logic [BODY_W-1:0] got,
                                input logic [BODY_W-1:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic predict_deframe(input logic [BYTE_W-1:0] rx);
      deframe_event_t   ev;
      logic [HDR_W-1:0] word;
      ev = '0;
      if (in_payload) begin
         bytes_left      = bytes_left - LEN_W'(1);
         ev.event_kind   = EV_PAYLOAD;
         ev.payload_byte = rx;
         ev.payload_kind = cur_kind;
         if (bytes_left == '0) begin
            ev.payload_last = 1'b1;
            in_payload      = 1'b0;
         end
         expected_events.push_back(ev);
      end else if (hdr_count != 2'd3) begin
         hdr_shift = hdr_shift | (SHIFT_W'(rx) << (8 * hdr_count));
         hdr_count = hdr_count + 2'd1;
      end else begin
         word      = {rx, hdr_shift};
         hdr_count = '0;
         hdr_shift = '0;
         if (header_crc4(word[BODY_W-1:0]) != word[HDR_W-1:BODY_W]) begin
            ev.event_kind = EV_CRC_BAD;
            expected_events.push_back(ev);
         end else begin
            case (word[3:0])
               TYPE_BEACON, TYPE_PING: begin
                  ev.event_kind  = (word[3:0] == TYPE_BEACON) ? EV_BEACON : EV_PING;
                  ev.header_body = word[BODY_W-1:0];
                  expected_events.push_back(ev);
               end
               TYPE_ERROR: begin
                  ev.event_kind = EV_ERROR;
                  ev.error_code = word[15:8];
                  expected_events.push_back(ev);
               end
               TYPE_RESPONSE, TYPE_ASYNC: begin
                  // empty payloads leave the receiver in header mode
                  if (word[16:4] != '0) begin
                     bytes_left = word[16:4];
                     cur_kind   = (word[3:0] == TYPE_ASYNC) ? PKIND_ASYNC : PKIND_RESPONSE;
                     in_payload = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   endtask

   task automatic check_event();
      deframe_event_t want;
      if (expected_events.size() == 0) begin
         report_mismatch("event with none expected, event_kind", rsp_event_kind, '0);
      end else begin
         want = expected_events.pop_front();
         compare_field("event_kind", rsp_event_kind, want.event_kind);
         compare_field("header_body", rsp_header_body, want.header_body);
         compare_field("error_code", rsp_error_code, want.error_code);
         compare_field("payload_byte", rsp_payload_byte, want.payload_byte);
         compare_field("payload_kind", rsp_payload_kind, want.payload_kind);
         compare_field("payload_last", rsp_payload_last, want.payload_last);
      end
   endtask

   // Retire the event first: it always belongs to an earlier byte.
   always @(posedge clock) begin
      if (reset) begin
         in_payload = 1'b0;
         hdr_count  = '0;
         hdr_shift  = '0;
         bytes_left = '0;
         cur_kind   = 1'b0;
         expected_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_event();
         end
         if (req_valid && !req_stall) begin
            predict_deframe(req_rx_byte);
         end
      end
      outstanding <= expected_events.size();
   end

endmodule

[tb/packet_header_crc_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_header_crc_deframer_tb
// Feeds the deframer a byte stream of directed and random packets in bursts
// under random result stalls; a checker beside the block scores the events.
// ----------------------------------------------------------------------------
module packet_header_crc_deframer_tb;
   import phcd_pkg::*;
   import deframe_crc_pkg::*;

   localparam int RANDOM_BYTES   = 360;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS} stall_mode_e;

   typedef struct packed {
      logic                drain_first;
      logic [BYTE_W-1:0]   data;
   } line_byte_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_event_kind;
   logic [BODY_W-1:0]   rsp_header_body;
   logic [BYTE_W-1:0]   rsp_error_code;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic                rsp_payload_kind;
   logic                rsp_payload_last;

   int                  fail_count;
   int                  outstanding;
   int                  idle_cycles = 0;
   logic                line_active;

   line_byte_t          line_bytes[$];

   packet_header_crc_deframer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_header_body  (rsp_header_body),
      .rsp_error_code   (rsp_error_code),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_kind (rsp_payload_kind),
      .rsp_payload_last (rsp_payload_last)
   );

   phcd_deframe_checker CHECK (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_header_body  (rsp_header_body),
      .rsp_error_code   (rsp_error_code),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_kind (rsp_payload_kind),
      .rsp_payload_last (rsp_payload_last),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   assign line_active = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);

   always @(posedge clock) begin
      if (reset || line_active) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: alternate between no stalls, coin flips and long runs.
   initial begin : rsp_backpressure
      stall_mode_e mode;
      int          span;
      int          run_left;
      logic        run_value;
      run_left  = 0;
      run_value = 1'b0;
      forever begin
         mode = stall_mode_e'($urandom_range(0, 2));
         span = $urandom_range(16, 160);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
               STALL_RUNS: begin
                  if (run_left == 0) begin
                     run_value = ~run_value;
                     run_left  = $urandom_range(1, 30);
                  end
                  run_left--;
                  rsp_stall <= run_value;
               end
            endcase
         end
      end
   end

   function automatic logic [HDR_W-1:0] sealed_header(input logic [BODY_W-1:0] body);
      return {header_crc4(body), body};
   endfunction

   task automatic push_word(input logic [HDR_W-1:0] word, input logic drain);
      for (int i = 0; i < 4; i++) begin
         line_bytes.push_back({drain && (i == 0), word[8*i +: 8]});
      end
   endtask

   task automatic push_payload_packet(input logic [3:0] ptype, input logic [LEN_W-1:0] len,
                                      input logic drain);
      push_word(sealed_header({11'($urandom), len, ptype}), drain);
      for (int i = 0; i < len; i++) begin
         line_bytes.push_back({1'b0, 8'($urandom)});
      end
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_line_bytes();
      line_byte_t next;
      int         burst_left;
      int         gap;
      burst_left = 0;
      while (line_bytes.size() != 0) begin
         next = line_bytes.pop_front();
         gap  = 0;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (gap != 0 || next.drain_first) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            if (next.drain_first) begin
               wait_for_results();
            end
         end
         req_valid   <= 1'b1;
         req_rx_byte <= next.data;
         do @(posedge clock); while (req_stall);
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int         pick;
      int         base;
      logic [3:0] ptype;
      logic       drain;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every event and each odd header
      push_word(sealed_header(28'hFFFFFF5), 1'b0);
      push_word(sealed_header(28'h0000006), 1'b0);
      push_word(sealed_header(28'h000FF0F), 1'b0);
      push_word(sealed_header(28'h1234565) ^ {4'hF, 28'h0}, 1'b0);
      push_word(sealed_header({11'h7FF, 13'd1, TYPE_RESPONSE}), 1'b0);
      line_bytes.push_back({1'b0, 8'hFF});
      push_word(sealed_header({11'h5A5, 13'd0, TYPE_RESPONSE}), 1'b0);
      push_word(sealed_header(28'h0000000), 1'b0);

      // hold the first random packet until the directed events are all in
      drain = 1'b1;
      base  = line_bytes.size();
      while (line_bytes.size() - base < RANDOM_BYTES) begin
         pick = $urandom_range(0, 19);
         if (pick < 7) begin
            ptype = $urandom_range(0, 1) ? TYPE_ASYNC : TYPE_RESPONSE;
            push_payload_packet(ptype, ($urandom_range(0, 7) == 0) ?
                                LEN_W'($urandom_range(9, 64)) :
                                LEN_W'($urandom_range(1, 8)), drain);
         end else if (pick < 10) begin
            push_word(sealed_header({24'($urandom), TYPE_BEACON}), drain);
         end else if (pick < 12) begin
            push_word(sealed_header({24'($urandom), TYPE_PING}), drain);
         end else if (pick < 14) begin
            push_word(sealed_header({24'($urandom), TYPE_ERROR}), drain);
         end else if (pick < 16) begin
            push_word(sealed_header(28'($urandom)) ^ {4'($urandom_range(1, 15)), 28'h0},
                      drain);
         end else if (pick == 16) begin
            ptype = $urandom_range(0, 1) ? TYPE_ASYNC : TYPE_RESPONSE;
            push_payload_packet(ptype, '0, drain);
         end else if (pick == 17) begin
            do ptype = 4'($urandom_range(0, 15));
            while (ptype == TYPE_BEACON || ptype == TYPE_PING || ptype == TYPE_ERROR ||
                   ptype == TYPE_RESPONSE || ptype == TYPE_ASYNC);
            push_word(sealed_header({24'($urandom), ptype}), drain);
         end else begin
            push_word($urandom, drain);
         end
         drain = ($urandom_range(0, 29) == 0);
      end

      // one long payload with an upper length bit set, then a closing beacon
      push_payload_packet(TYPE_ASYNC, 13'h100, 1'b0);
      push_word(sealed_header({24'($urandom), TYPE_BEACON}), 1'b0);

      send_line_bytes();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/phcd_pkg.sv
rtl/phcd_hdr_decode.sv
rtl/packet_header_crc_deframer.sv
rtl/phcd_checker.sv
tb/phcd_deframe_checker.sv
tb/packet_header_crc_deframer_tb.sv
